### hw/rtl/fra_pkg.sv
// Package for the fraction reduce-and-add block: widths, commands, controller states.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
package fra_pkg;
    localparam int NumW = 33;
    localparam int DenW = 32;
    localparam int EuW  = 34;
    localparam int CntW = 6;

    localparam logic CMD_REDUCE = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_SUM, ST_CHECK, ST_DIV, ST_STEP, ST_QNUM, ST_QDEN, ST_DONE
    } fra_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic div_start;
        logic div_step;
        logic eu_step;
        logic sel_num;
        logic sel_den;
        logic take_num;
        logic finish;
    } fra_cmd_t;

    typedef struct packed {
        logic bad;
        logic b_zero;
        logic g_unit;
        logic div_last;
    } fra_stat_t;
endpackage

### hw/rtl/fra_ctrl.sv
// Controller of the fraction block: sequences multiply, Euclid steps and the final divides.
// Depends on fra_pkg.
`timescale 1ns / 1ps
module fra_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  fra_pkg::fra_stat_t stat,
    output fra_pkg::fra_cmd_t  cmd,
    output logic               busy
);
    import fra_pkg::*;

    fra_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_MUL;
            ST_MUL:   state_next = stat.bad ? ST_DONE : ST_SUM;
            ST_SUM:   state_next = ST_CHECK;
            ST_CHECK: state_next = stat.b_zero ? ST_QNUM : ST_DIV;
            ST_DIV:   if (stat.div_last) state_next = ST_STEP;
            ST_STEP:  state_next = ST_CHECK;
            ST_QNUM:  begin
                if (stat.g_unit) state_next = ST_DONE;
                else if (stat.div_last) state_next = ST_QDEN;
            end
            ST_QDEN:  if (stat.div_last) state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:  cmd.load = start;
            ST_MUL:   cmd.mul = 1'b1;
            ST_SUM:   cmd.sum = 1'b1;
            ST_CHECK: begin
                // The first divide of the quotient phase is armed here as well.
                cmd.div_start = 1'b1;
                cmd.sel_num = stat.b_zero;
            end
            ST_DIV:   cmd.div_step = 1'b1;
            ST_STEP:  cmd.eu_step = 1'b1;
            ST_QNUM:  begin
                cmd.div_step = !stat.g_unit;
                cmd.sel_num = 1'b1;
                cmd.take_num = stat.div_last && !stat.g_unit;
                // Arm the denominator divide once the numerator quotient is taken.
                cmd.div_start = stat.div_last && !stat.g_unit;
                cmd.sel_den = stat.div_last;
            end
            ST_QDEN:  begin
                cmd.div_step = 1'b1;
                cmd.sel_den = 1'b1;
            end
            ST_DONE:  cmd.finish = 1'b1;
            default:  cmd = '0;
        endcase
    end
endmodule

### hw/rtl/fra_dp.sv
// Datapath of the fraction block: operand registers, two multipliers, a restoring divider.
// Depends on fra_pkg.
`timescale 1ns / 1ps
module fra_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fra_pkg::fra_cmd_t         cmd,
    input  logic                      command,
    input  logic signed [15:0]        num_a,
    input  logic signed [15:0]        den_a,
    input  logic signed [15:0]        num_b,
    input  logic signed [15:0]        den_b,
    output fra_pkg::fra_stat_t        stat,
    output logic                      done,
    output logic signed [32:0]        num_out,
    output logic signed [31:0]        den_out,
    output logic                      bad_denominator
);
    import fra_pkg::*;

    logic                   cmd_reg;
    logic signed [15:0]     na_reg, da_reg, nb_reg, db_reg;
    logic signed [31:0]     p1_reg, p2_reg;
    logic signed [EuW-1:0]  n_reg, d_reg, a_reg, b_reg;
    logic                   bad_reg;
    // Divider on magnitudes: dividend shifts out, remainder builds up.
    logic [EuW-1:0]         dq_reg, rem_reg, dv_reg;
    logic                   neg_q_reg, neg_r_reg;
    logic [CntW-1:0]        cnt_reg;
    logic signed [EuW-1:0]  q_num_reg;
    logic                   done_reg;
    logic signed [32:0]     num_out_reg;
    logic signed [31:0]     den_out_reg;
    logic                   bad_out_reg;

    logic signed [EuW-1:0]  dividend, divisor;
    logic [EuW:0]           trial;
    logic [EuW-1:0]         rem_shift;
    logic signed [EuW-1:0]  quo_s, rem_s;
    logic [EuW-1:0]         q_last;
    logic signed [EuW-1:0]  q_last_s;
    logic signed [31:0]     mul_x, mul_y;

    always_comb
    begin
        dividend = a_reg;
        divisor  = b_reg;
        if (cmd.sel_num)
        begin
            dividend = n_reg;
            divisor  = a_reg;
        end
        if (cmd.sel_den)
        begin
            dividend = d_reg;
            divisor  = a_reg;
        end
        rem_shift = {rem_reg[EuW-2:0], dq_reg[EuW-1]};
        trial = {1'b0, rem_shift} - {1'b0, dv_reg};
        quo_s = neg_q_reg ? -$signed(dq_reg) : $signed(dq_reg);
        rem_s = neg_r_reg ? -$signed(rem_reg) : $signed(rem_reg);
        // Quotient including the step taken in the current cycle.
        q_last = {dq_reg[EuW-2:0], ~trial[EuW]};
        q_last_s = neg_q_reg ? -$signed(q_last) : $signed(q_last);
        mul_x = cmd.mul ? 32'(na_reg) : 32'(nb_reg);
        mul_y = 32'(db_reg);
        if (!cmd.mul)
            mul_y = 32'(da_reg);
    end

    assign stat.bad = (da_reg == 0) || (cmd_reg == CMD_ADD && db_reg == 0);
    assign stat.b_zero = (b_reg == '0);
    assign stat.g_unit = (a_reg == EuW'(1)) || (a_reg == -EuW'(1));
    assign stat.div_last = (cnt_reg == CntW'(EuW - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            na_reg <= num_a;
            da_reg <= den_a;
            nb_reg <= num_b;
            db_reg <= den_b;
        end
        if (cmd.mul)
        begin
            bad_reg <= (da_reg == 0) || (cmd_reg == CMD_ADD && db_reg == 0);
            p1_reg <= mul_x * mul_y;
            p2_reg <= 32'(da_reg) * 32'(db_reg);
        end
        if (cmd.sum)
        begin
            if (cmd_reg == CMD_ADD)
            begin
                n_reg <= EuW'(p1_reg) + EuW'(mul_x * mul_y);
                d_reg <= EuW'(p2_reg);
                a_reg <= EuW'(p2_reg);
                b_reg <= EuW'(p1_reg) + EuW'(mul_x * mul_y);
            end
            else
            begin
                n_reg <= EuW'(na_reg);
                d_reg <= EuW'(da_reg);
                a_reg <= EuW'(da_reg);
                b_reg <= EuW'(na_reg);
            end
        end
        if (cmd.div_start)
        begin
            dq_reg <= dividend[EuW-1] ? EuW'(-dividend) : EuW'(dividend);
            dv_reg <= divisor[EuW-1] ? EuW'(-divisor) : EuW'(divisor);
            rem_reg <= '0;
            neg_q_reg <= dividend[EuW-1] ^ divisor[EuW-1];
            neg_r_reg <= dividend[EuW-1];
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (!trial[EuW])
            begin
                rem_reg <= trial[EuW-1:0];
                dq_reg <= {dq_reg[EuW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                dq_reg <= {dq_reg[EuW-2:0], 1'b0};
            end
        end
        if (cmd.eu_step)
        begin
            a_reg <= b_reg;
            b_reg <= rem_s;
        end
        if (cmd.take_num)
            q_num_reg <= q_last_s;
        if (cmd.finish)
        begin
            bad_out_reg <= bad_reg;
            if (bad_reg)
            begin
                num_out_reg <= '0;
                den_out_reg <= '0;
            end
            else if (stat.g_unit || a_reg == '0)
            begin
                num_out_reg <= n_reg[32:0];
                den_out_reg <= d_reg[31:0];
            end
            else
            begin
                num_out_reg <= q_num_reg[32:0];
                den_out_reg <= quo_s[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    assign done = done_reg;
    assign num_out = num_out_reg;
    assign den_out = den_out_reg;
    assign bad_denominator = bad_out_reg;
endmodule

### hw/rtl/fraction_reduce_and_add.sv
// Top level of the fraction reduce-and-add block: controller plus datapath.
// Depends on fra_pkg, fra_ctrl and fra_dp.
`timescale 1ns / 1ps
// One item is taken when start is high and busy is low, one at a time. A zero denominator
// skips the Euclid steps and divides, going from the multiply state straight to the done
// state; otherwise the time an item takes is set by the one bit-serial 34-bit divider
// that every Euclid remainder step and both final quotients share. The result is shown
// for one cycle with done high; the receiver cannot stall it, so it must take every
// transfer.
module fraction_reduce_and_add (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               command,
    input  logic signed [15:0] num_a,
    input  logic signed [15:0] den_a,
    input  logic signed [15:0] num_b,
    input  logic signed [15:0] den_b,
    output logic               done,
    output logic signed [32:0] num_out,
    output logic signed [31:0] den_out,
    output logic               bad_denominator
);
    import fra_pkg::*;

    fra_cmd_t  cmd;
    fra_stat_t stat;

    fra_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
    );

    fra_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .command(command),
        .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
        .stat(stat), .done(done), .num_out(num_out), .den_out(den_out),
        .bad_denominator(bad_denominator)
    );
endmodule

### hw/rtl/fra_checker.sv
// Port-level checker for the fraction block, bound to the top level.
// Depends on fra_pkg only for its house import.
`timescale 1ns / 1ps
module fra_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [32:0] num_out,
    input logic signed [31:0] den_out,
    input logic               bad_denominator
);
    import fra_pkg::*;

    // An accepted transfer makes the block busy next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accept did not raise busy");
    // A result is only reported after work was in progress.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without work");
    // The strobe is a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    // A bad denominator gives zero fields.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_denominator |-> num_out == 0 && den_out == 0)
        else $error("bad denominator with nonzero fields");
    // Every good result has a nonzero denominator.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !bad_denominator |-> den_out != 0) else $error("zero denominator result");
endmodule

bind fraction_reduce_and_add fra_checker u_fra_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .num_out(num_out), .den_out(den_out), .bad_denominator(bad_denominator)
);

### tb/tb_fraction_reduce_and_add.sv
// Self-checking testbench for the fraction reduce-and-add block.
// Depends on fra_pkg and fraction_reduce_and_add; drives directed then random commands.
`timescale 1ns / 1ps
module tb_fraction_reduce_and_add;
    import fra_pkg::*;

    typedef struct {
        logic               cmd;
        logic signed [15:0] na;
        logic signed [15:0] da;
        logic signed [15:0] nb;
        logic signed [15:0] db;
        bit                 typed;
        logic signed [32:0] n_exp;
        logic signed [31:0] d_exp;
        logic               bad_exp;
    } frac_row_t;

    typedef struct {
        logic signed [32:0] n;
        logic signed [31:0] d;
        logic               bad;
    } frac_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               command = CMD_REDUCE;
    logic signed [15:0] num_a = '0;
    logic signed [15:0] den_a = '0;
    logic signed [15:0] num_b = '0;
    logic signed [15:0] den_b = '0;
    logic               done;
    logic signed [32:0] num_out;
    logic signed [31:0] den_out;
    logic               bad_denominator;

    frac_res_t   reduced_q[$];
    int          errors = 0;
    int          results_seen = 0;
    int          sent = 0;
    longint      cycles = 0;
    int          send_idle_pct = 29;
    frac_row_t   dir_rows[$];

    fraction_reduce_and_add u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b), .done(done),
        .num_out(num_out), .den_out(den_out), .bad_denominator(bad_denominator)
    );

    always #2 clk = ~clk;

    // Exact rational sum for add commands, then Euclid with truncating remainder on 64-bit values.
    function automatic frac_res_t reduce_fraction(frac_row_t r);
        frac_res_t res;
        longint n, d, a, b, t;
        res.n = '0;
        res.d = '0;
        res.bad = 1'b0;
        if (r.da == 0 || (r.cmd == CMD_ADD && r.db == 0)) begin
            res.bad = 1'b1;
            return res;
        end
        if (r.cmd == CMD_ADD) begin
            d = longint'(r.da) * longint'(r.db);
            n = longint'(r.na) * longint'(r.db) + longint'(r.nb) * longint'(r.da);
        end
        else begin
            n = r.na;
            d = r.da;
        end
        a = d;
        b = n;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        if (a != 1 && a != -1 && a != 0) begin
            n = n / a;
            d = d / a;
        end
        res.n = n[32:0];
        res.d = d[31:0];
        return res;
    endfunction

    function automatic frac_row_t mk(logic c, int na, int da, int nb, int db);
        frac_row_t r;
        r.cmd = c;
        r.na = na[15:0];
        r.da = da[15:0];
        r.nb = nb[15:0];
        r.db = db[15:0];
        r.typed = 1'b0;
        r.n_exp = '0;
        r.d_exp = '0;
        r.bad_exp = 1'b0;
        return r;
    endfunction

    function automatic frac_row_t mk_exp(logic c, int na, int da, int nb, int db,
                                         longint ne, longint de, logic be);
        frac_row_t r;
        r = mk(c, na, da, nb, db);
        r.typed = 1'b1;
        r.n_exp = ne[32:0];
        r.d_exp = de[31:0];
        r.bad_exp = be;
        return r;
    endfunction

    // Called at a falling edge; busy only moves at rising edges, so a low busy seen here
    // means the next rising edge takes the transfer.
    task automatic send_fraction(frac_row_t r);
        frac_res_t e;
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        while (busy) @(negedge clk);
        command <= r.cmd;
        num_a <= r.na;
        den_a <= r.da;
        num_b <= r.nb;
        den_b <= r.db;
        start <= 1'b1;
        if (r.typed) begin
            e.n = r.n_exp;
            e.d = r.d_exp;
            e.bad = r.bad_exp;
        end
        else e = reduce_fraction(r);
        @(negedge clk);
        reduced_q.push_back(e);
        sent++;
        start <= 1'b0;
    endtask

    function automatic int rand_s16();
        case ($urandom_range(5))
            0: return $urandom_range(7) - 3;
            1: return $urandom_range(1) ? 32767 : -32768;
            2: return $urandom_range(200) - 100;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int rand_den();
        return ($urandom_range(49) == 0) ? 0 : rand_s16();
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            cycles <= cycles + 1;
            if (done) begin
                results_seen <= results_seen + 1;
                if (reduced_q.size() == 0) begin
                    $display("%0t: unexpected result num=%0d den=%0d bad=%0b",
                             $time, num_out, den_out, bad_denominator);
                    errors <= errors + 1;
                end
                else begin
                    frac_res_t e;
                    e = reduced_q.pop_front();
                    if (num_out !== e.n || den_out !== e.d || bad_denominator !== e.bad) begin
                        $display("%0t: mismatch expected num=%0d den=%0d bad=%0b,",
                                 $time, e.n, e.d, e.bad);
                        $display("%0t:          got num=%0d den=%0d bad=%0b",
                                 $time, num_out, den_out, bad_denominator);
                        errors <= errors + 1;
                    end
                end
            end
            if (cycles > 3000000) begin
                $display("%0t: timeout with %0d results outstanding", $time, reduced_q.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        frac_row_t r;
        int phase, k;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes, zero denominators, zero numerators and sign cases.
        dir_rows.push_back(mk_exp(CMD_REDUCE, 5, 0, 1, 1, 0, 0, 1'b1));
        dir_rows.push_back(mk_exp(CMD_ADD, 5, 3, 1, 0, 0, 0, 1'b1));
        dir_rows.push_back(mk_exp(CMD_ADD, 0, 0, 0, 0, 0, 0, 1'b1));
        dir_rows.push_back(mk_exp(CMD_REDUCE, 0, 7, 0, 0, 0, 1, 1'b0));
        dir_rows.push_back(mk_exp(CMD_REDUCE, 0, -1, 0, 0, 0, -1, 1'b0));
        dir_rows.push_back(mk_exp(CMD_REDUCE, 0, 1, 0, 0, 0, 1, 1'b0));
        dir_rows.push_back(mk_exp(CMD_REDUCE, 3, 5, -7, 0, 3, 5, 1'b0));
        dir_rows.push_back(mk(CMD_REDUCE, 6, -4, 0, 0));
        dir_rows.push_back(mk(CMD_REDUCE, -6, 4, 0, 0));
        dir_rows.push_back(mk(CMD_REDUCE, -6, -4, 0, 0));
        dir_rows.push_back(mk(CMD_REDUCE, -32768, -32768, 0, 0));
        dir_rows.push_back(mk(CMD_REDUCE, 32767, -32768, 0, 0));
        dir_rows.push_back(mk(CMD_REDUCE, 32767, 32767, 0, 0));
        dir_rows.push_back(mk(CMD_ADD, -32768, -32768, -32768, -32768));
        dir_rows.push_back(mk(CMD_ADD, 32767, 32767, 32767, 32767));
        dir_rows.push_back(mk(CMD_ADD, -32768, 32767, -32768, 32767));
        dir_rows.push_back(mk(CMD_ADD, 32767, -32768, 32767, 1));
        dir_rows.push_back(mk(CMD_ADD, 1, 2, -1, 2));
        dir_rows.push_back(mk(CMD_ADD, 1, 3, 1, 6));
        dir_rows.push_back(mk(CMD_ADD, 46368, 28657, 28657, 17711));
        dir_rows.push_back(mk(CMD_ADD, -5, 7, 3, -11));
        foreach (dir_rows[i]) send_fraction(dir_rows[i]);

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 80 : 0;
            for (k = 0; k < 95; k++) begin
                r = mk($urandom_range(1), rand_s16(), rand_den(), rand_s16(), rand_den());
                send_fraction(r);
                // Hold off once per phase until the block has drained.
                if (k == 40) while (reduced_q.size() != 0) @(negedge clk);
            end
        end

        while (reduced_q.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        $display("Covered %0d commands (reduce and add, zero and extreme operands), %0d results.",
                 sent, results_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### fraction_reduce_and_add.f
hw/rtl/fra_pkg.sv
hw/rtl/fra_ctrl.sv
hw/rtl/fra_dp.sv
hw/rtl/fraction_reduce_and_add.sv
hw/rtl/fra_checker.sv
tb/tb_fraction_reduce_and_add.sv
